// ===== rtl/core/signed_int_to_decimal_ascii_defines.svh =====
// Assertion macros shared by the checker of the decimal text converter.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define I2A_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/i2a_pkg.sv =====
// Shared types and constants of the signed integer to decimal text converter.
// Used by the controller, the datapath and the top level.
package i2a_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned PTR_W      = $clog2(MAX_DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  // ceil(2^35 / 10); (x * RECIP_10) >> 35 equals x / 10 for every 32-bit x.
  localparam logic [DATA_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int unsigned       RECIP_SHIFT = 35;
  localparam int unsigned       QUOT_W      = 2 * DATA_W - RECIP_SHIFT;

  typedef struct packed {
    logic load;        // capture a new request
    logic mul;         // form magnitude times reciprocal
    logic div_step;    // store one digit and replace magnitude by quotient
    logic emit_sign;   // load the minus sign into the output register
    logic emit_digit;  // load the digit under the pointer
  } cmd_t;

  typedef struct packed {
    logic neg;         // request was negative
    logic conv_done;   // the current division step yields the last digit
    logic ptr_zero;    // pointer sits on the least significant digit
    logic out_free;    // output register can take a character this cycle
  } status_t;

endpackage

// ===== rtl/core/i2a_ctrl.sv =====
// Controller of the decimal text converter: sequences conversion and output.
// Depends on i2a_pkg for the command and status types.
module i2a_ctrl
  import i2a_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.conv_done) begin
          state_nxt = status.neg ? ST_SIGN : ST_EMIT;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.ptr_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/i2a_dp.sv =====
// Datapath of the decimal text converter: reciprocal divider, digit buffer
// and output register. Depends on i2a_pkg for constants and the cmd/status types.
module i2a_dp
  import i2a_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [DATA_W-1:0] in_value,
  input  cmd_t                     cmd,
  output status_t                  status,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CHAR_W-1:0]        out_character,
  output logic                     out_last_char
);

  logic                   neg_r;
  logic [DATA_W-1:0]      mag_r;
  logic [2*DATA_W-1:0]    prod_r;
  logic [PTR_W-1:0]       ptr_r;
  logic [DIGIT_W-1:0]     digit_buf_r [MAX_DIGITS];
  logic                   out_valid_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_last_r;

  logic [DATA_W-1:0]      raw;
  logic [QUOT_W-1:0]      quot;
  logic [DATA_W-1:0]      quot_x10;
  logic [DATA_W-1:0]      rem_full;
  logic [DIGIT_W-1:0]     digit;

  assign raw      = DATA_W'(unsigned'(in_value));
  assign quot     = prod_r[2*DATA_W-1:RECIP_SHIFT];
  assign quot_x10 = (DATA_W'(quot) << 3) + (DATA_W'(quot) << 1);
  assign rem_full = mag_r - quot_x10;
  assign digit    = rem_full[DIGIT_W-1:0];

  assign status.neg       = neg_r;
  assign status.conv_done = (quot == '0) || (ptr_r == PTR_W'(MAX_DIGITS - 1));
  assign status.ptr_zero  = (ptr_r == '0);
  assign status.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= raw[DATA_W-1];
      mag_r <= raw[DATA_W-1] ? (DATA_W'(0) - raw) : raw;
      ptr_r <= '0;
    end
    if (cmd.mul) begin
      prod_r <= (2*DATA_W)'(mag_r) * (2*DATA_W)'(RECIP_10);
    end
    if (cmd.div_step) begin
      digit_buf_r[ptr_r] <= digit;
      mag_r              <= DATA_W'(quot);
      if (!status.conv_done) begin
        ptr_r <= ptr_r + 1'b1;
      end
    end
    if (cmd.emit_digit) begin
      ptr_r <= ptr_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= CHAR_ZERO + CHAR_W'(digit_buf_r[ptr_r]);
      out_last_r <= (ptr_r == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last_char = out_last_r;

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// Top level of the signed 32-bit integer to decimal ASCII text converter.
// Instantiates i2a_ctrl and i2a_dp; depends on i2a_pkg.
//
//   Channel | Direction | Handshake           | Payload
//   in      | input     | in_valid/in_ready   | in_value (32 b, signed)
//   out     | output    | out_valid/out_ready | out_character (6 b), out_last_char
//
// Each digit takes a multiply step, then a quotient and remainder step, and later a step
// to enter the output register; a negative request adds a step for the minus sign.
// The next request is accepted right after the last character enters the output register.
// Reset is synchronous, active low, and clears the controller state and output valid.
// A stall on out_ready holds the emitting controller with no loss of characters.
module signed_int_to_decimal_ascii
  import i2a_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CHAR_W-1:0]        out_character,
  output logic                     out_last_char
);

  // Commands flow from the controller to the datapath, status flows back.
  cmd_t    cmd;
  status_t status;

  // The controller owns the sequence: capture, then alternate multiply and
  // division steps until the quotient is zero or the buffer is full, then emit the optional sign and
  // the buffered digits from the most significant one down.
  i2a_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the magnitude, the digit buffer and the output register.
  // Digits are stored least significant first and read back in reverse order.
  i2a_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

endmodule

// ===== rtl/core/i2a_checker.sv =====
// Port-level checker of the decimal text converter, bound to the top level.
// Depends on i2a_pkg and the assertion macros in the defines header.
`include "signed_int_to_decimal_ascii_defines.svh"

module i2a_checker
  import i2a_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic signed [DATA_W-1:0] in_value,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [CHAR_W-1:0]        out_character,
  input logic                     out_last_char
);

  // A stalled character holds its value and flag.
  `I2A_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_character) && $stable(out_last_char),
    "output character changed while stalled")

  // Only a minus sign or a decimal digit ever leaves the block.
  `I2A_ASSERT_NOW(a_char_range, out_valid,
    out_character == CHAR_MINUS ||
    (out_character >= CHAR_ZERO && out_character <= CHAR_ZERO + 6'd9),
    "output character is neither a digit nor a minus sign")

  // The minus sign is never the final character of a request.
  `I2A_ASSERT_NOW(a_sign_not_last, out_valid && out_character == CHAR_MINUS,
    !out_last_char, "minus sign flagged as last character")

  // After a request is taken the block is busy converting it.
  `I2A_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "input ready right after an accepted request")

endmodule

bind signed_int_to_decimal_ascii i2a_checker u_i2a_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_value      (in_value),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_character (out_character),
  .out_last_char (out_last_char)
);
